// ----- design/qvu8_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quoted value UTF-8 checker.
// Holds the byte codes and UTF-8 lead ranges; depends on nothing.
package qvu8_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h27;
  localparam logic [7:0] DEL_BYTE    = 8'h7f;
  localparam logic [7:0] SPACE_BYTE  = 8'h20;

  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;

  localparam logic [1:0] CONT_TAG    = 2'b10;

  localparam logic [20:0] MIN_CP3    = 21'h000800;
  localparam logic [20:0] MIN_CP4    = 21'h010000;
  localparam logic [20:0] MAX_CP     = 21'h10ffff;
  localparam logic [20:0] SURR_LO    = 21'h00d800;
  localparam logic [20:0] SURR_HI    = 21'h00dfff;

  typedef logic [1:0]  cont_cnt_t;
  typedef logic [20:0] code_point_t;
  typedef logic [15:0] length_t;

endpackage

// ----- design/quoted_value_utf8_checker.sv -----
`timescale 1ns / 1ps
// Quoted value UTF-8 checker: unquotes one value and checks it as strict UTF-8 with no control bytes.
// Depends on qvu8_pkg.
//
// The block accepts one raw byte per cycle on the in_ channel and produces at
// most one transfer per byte on the out_ channel, in the cycle after acceptance.
// All decoding is done by a single layer of logic ahead of the result
// register, so the sustained rate is one byte per clock whenever the consumer
// keeps out_ready high; in_ready only drops while a result is held and not
// taken. A transfer carries a decoded byte, the end-of-value report, or both.
// On the end-of-value transfer out_value_ok and out_decoded_length are valid;
// the length saturates at VALUE_LIMIT or 65535, whichever is lower. The next
// byte after a final byte starts a new value.
module quoted_value_utf8_checker #(
  parameter int VALUE_LIMIT = 65535
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_end_of_value,
  output logic                  out_value_ok,
  output qvu8_pkg::length_t     out_decoded_length
);
  import qvu8_pkg::*;

  localparam length_t SAT_LIMIT = (VALUE_LIMIT > 65535) ? 16'hffff : 16'(VALUE_LIMIT);

  logic        at_first_r, at_first_nxt;
  logic        quoted_r, quoted_nxt;
  logic        pend_r, pend_nxt;
  cont_cnt_t   rem_r, rem_nxt;
  cont_cnt_t   tot_r, tot_nxt;
  code_point_t acc_r, acc_nxt;
  logic        err_r, err_nxt;
  length_t     cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bv_r, out_bv_nxt;
  logic        out_eov_r, out_eov_nxt;
  logic        out_ok_r, out_ok_nxt;
  length_t     out_len_r, out_len_nxt;

  logic        accept;
  logic        emit;
  logic        err_v;
  cont_cnt_t   rem_v;
  cont_cnt_t   tot_v;
  code_point_t acc_v;
  length_t     cnt_v;
  logic        final_err;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    emit  = 1'b0;
    err_v = err_r;
    rem_v = rem_r;
    tot_v = tot_r;
    acc_v = acc_r;
    cnt_v = cnt_r;
    at_first_nxt = at_first_r;
    quoted_nxt   = quoted_r;
    pend_nxt     = pend_r;

    if (at_first_r) begin
      at_first_nxt = 1'b0;
      if (in_byte == QUOTE_BYTE) begin
        quoted_nxt = 1'b1;
        if (in_last_byte) begin
          err_v = 1'b1;
        end
      end else begin
        quoted_nxt = 1'b0;
        emit = 1'b1;
      end
    end else if (quoted_r) begin
      if (in_last_byte) begin
        if (in_byte != QUOTE_BYTE || pend_r) begin
          err_v = 1'b1;
        end
        pend_nxt = 1'b0;
      end else if (pend_r) begin
        pend_nxt = 1'b0;
        if (in_byte != QUOTE_BYTE) begin
          err_v = 1'b1;
        end
        emit = 1'b1;
      end else if (in_byte == QUOTE_BYTE) begin
        pend_nxt = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end else begin
      if (in_byte == QUOTE_BYTE) begin
        err_v = 1'b1;
      end
      emit = 1'b1;
    end

    if (emit) begin
      if (in_byte < SPACE_BYTE || in_byte == DEL_BYTE) begin
        err_v = 1'b1;
      end
      if (rem_r == 2'd0) begin
        if (in_byte[7]) begin
          if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
            acc_v = {16'd0, in_byte[4:0]};
            tot_v = 2'd1;
            rem_v = 2'd1;
          end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
            acc_v = {17'd0, in_byte[3:0]};
            tot_v = 2'd2;
            rem_v = 2'd2;
          end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
            acc_v = {18'd0, in_byte[2:0]};
            tot_v = 2'd3;
            rem_v = 2'd3;
          end else begin
            err_v = 1'b1;
          end
        end
      end else if (in_byte[7:6] != CONT_TAG) begin
        err_v = 1'b1;
        rem_v = 2'd0;
      end else begin
        acc_v = {acc_r[14:0], in_byte[5:0]};
        rem_v = rem_r - 2'd1;
        if (rem_v == 2'd0) begin
          if ((tot_r == 2'd2 && acc_v < MIN_CP3) ||
              (tot_r == 2'd3 && acc_v < MIN_CP4) ||
              acc_v > MAX_CP ||
              (acc_v >= SURR_LO && acc_v <= SURR_HI)) begin
            err_v = 1'b1;
          end
        end
      end
      if (cnt_r < SAT_LIMIT) begin
        cnt_v = cnt_r + 16'd1;
      end
    end

    final_err = err_v || (rem_v != 2'd0) || (cnt_v == 16'd0);

    err_nxt = err_v;
    rem_nxt = rem_v;
    tot_nxt = tot_v;
    acc_nxt = acc_v;
    cnt_nxt = cnt_v;
    if (in_last_byte) begin
      at_first_nxt = 1'b1;
      quoted_nxt   = 1'b0;
      pend_nxt     = 1'b0;
      rem_nxt      = 2'd0;
      tot_nxt      = 2'd0;
      acc_nxt      = '0;
      err_nxt      = 1'b0;
      cnt_nxt      = '0;
    end

    out_byte_nxt = emit ? in_byte : 8'd0;
    out_bv_nxt   = emit;
    out_eov_nxt  = in_last_byte;
    out_ok_nxt   = in_last_byte && !final_err;
    out_len_nxt  = in_last_byte ? cnt_v : 16'd0;

    if (accept) begin
      out_valid_nxt = emit || in_last_byte;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_first_r  <= 1'b1;
      quoted_r    <= 1'b0;
      pend_r      <= 1'b0;
      rem_r       <= 2'd0;
      tot_r       <= 2'd0;
      acc_r       <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        at_first_r <= at_first_nxt;
        quoted_r   <= quoted_nxt;
        pend_r     <= pend_nxt;
        rem_r      <= rem_nxt;
        tot_r      <= tot_nxt;
        acc_r      <= acc_nxt;
        err_r      <= err_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
      out_bv_r   <= out_bv_nxt;
      out_eov_r  <= out_eov_nxt;
      out_ok_r   <= out_ok_nxt;
      out_len_r  <= out_len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = out_bv_r;
  assign out_end_of_value   = out_eov_r;
  assign out_value_ok       = out_ok_r;
  assign out_decoded_length = out_len_r;

  // An accepted final byte leaves the block ready to start a new value.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (at_first_r && !quoted_r && !pend_r &&
                                  rem_r == 2'd0 && cnt_r == 16'd0 && !err_r))
    else $error("state not cleared after final byte");

  // A transfer without a decoded byte can only be an end-of-value report.
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_end_of_value)
    else $error("empty result transfer");

  // A passing value has decoded at least one byte.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_ok) |-> (out_end_of_value && out_decoded_length != 16'd0))
    else $error("value reported good with zero length");

  // The reported length never exceeds the saturation limit.
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_decoded_length <= SAT_LIMIT))
    else $error("decoded length above limit");

  // The running count never exceeds the saturation limit.
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SAT_LIMIT)
    else $error("byte count above limit");

endmodule
